// ===== sv/tcd_pkg.sv =====
// shared types, constants and helpers for the triangle coverage and depth block
// used by every module of the block; depends on nothing
package tcd_pkg;

	localparam int COORD_W   = 20;
	localparam int OPND_W    = 22;
	localparam int PROD_W    = 2 * OPND_W;
	localparam int HALF_W    = 21;
	localparam int PLANE_W   = 42;
	localparam int DET_W     = 62;
	localparam int ACC_W     = 64;
	localparam int REM_W     = PLANE_W + 2;
	localparam int QDEPTH    = 4;
	localparam int QIDX_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int STEP_W    = 4;
	localparam int DIVCNT_W  = $clog2(ACC_W);

	localparam logic [STEP_W-1:0] BUILD_LAST = STEP_W'(11);
	localparam logic [STEP_W-1:0] TEST_LAST  = STEP_W'(9);
	localparam logic [DIVCNT_W-1:0] DIV_LAST = DIVCNT_W'(ACC_W - 1);
	localparam logic [1:0] VSEL_NONE = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_TEST  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]                op;
		logic [1:0]                vertex_sel;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic                      inside_res;
		logic signed [COORD_W-1:0] depth;
		logic                      depth_valid;
	} out_item_t;

	typedef struct packed {
		op_t                       op;
		logic [1:0]                sel;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} cmd_t;

	typedef enum logic [2:0] {
		DST_A   = 3'd0,
		DST_B   = 3'd1,
		DST_C   = 3'd2,
		DST_D   = 3'd3,
		DST_E0  = 3'd4,
		DST_E1  = 3'd5,
		DST_E2  = 3'd6,
		DST_NUM = 3'd7
	} dst_t;

	typedef struct packed {
		logic valid;
		logic shift;
		logic neg;
		logic first;
		logic init_det;
		logic last;
		dst_t dst;
	} mac_tag_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'd0,
		BK_MAC   = 3'd1,
		BK_DRAIN = 3'd2,
		BK_SETUP = 3'd3,
		BK_DIV   = 3'd4,
		BK_DONE  = 3'd5
	} bk_state_t;

	function automatic logic signed [OPND_W-1:0] diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		diff = OPND_W'(a) - OPND_W'(b);
	endfunction

endpackage

// ===== sv/triangle_coverage_and_depth.sv =====
// top level: vertex load, plane build and pixel coverage/depth test
// the back end executes one item at a time; a build or a test runs its products (12 or 10)
// through the shared multiply-accumulate unit, and a test then runs the 64-bit serial divider
// a test does not start while an earlier result is still waiting to be taken
// the front stage and a 4-entry command queue keep taking items meanwhile
// reset clears vertices, plane registers, queue and the result valid flag; no clearing pass
module triangle_coverage_and_depth (
	input  logic               clk,
	input  logic               arst_n,
	input  tcd_pkg::in_item_t  item,
	input  logic               push,
	output logic               full,
	output tcd_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	logic          q_push, q_full, q_pop, q_empty;
	tcd_pkg::cmd_t q_wr_cmd, q_rd_cmd;

	tcd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.q_push (q_push),
		.q_cmd  (q_wr_cmd),
		.q_full (q_full)
	);

	tcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	tcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (q_rd_cmd),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	// a command blocked by a full queue is held by the front stage
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_full) |=> (q_push && $stable(q_wr_cmd)))
		else $error("front stage dropped a blocked command");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end took from an empty queue");

	// a waiting result is never replaced before it is taken
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

// ===== sv/tcd_front.sv =====
// front stage: takes items, drops those with no effect, classifies the rest
// depends on tcd_pkg
module tcd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  tcd_pkg::in_item_t item,
	input  logic             push,
	output logic             full,
	output logic             q_push,
	output tcd_pkg::cmd_t    q_cmd,
	input  logic             q_full
);

	logic          v_s1;
	tcd_pkg::cmd_t cmd_s1;
	logic          keep;

	always_comb begin
		case (tcd_pkg::op_t'(item.op))
			tcd_pkg::OP_LOAD:  keep = (item.vertex_sel != tcd_pkg::VSEL_NONE);
			tcd_pkg::OP_BUILD: keep = 1'b1;
			tcd_pkg::OP_TEST:  keep = 1'b1;
			default:           keep = 1'b0;
		endcase
	end

	assign full   = v_s1 && q_full;
	assign q_push = v_s1;
	assign q_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!full) begin
			v_s1 <= push && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			cmd_s1.op  <= tcd_pkg::op_t'(item.op);
			cmd_s1.sel <= item.vertex_sel;
			cmd_s1.x   <= item.pos_x;
			cmd_s1.y   <= item.pos_y;
			cmd_s1.z   <= item.pos_z;
		end
	end

endmodule

// ===== sv/tcd_queue.sv =====
// short command queue between the front stage and the execution back end
// depends on tcd_pkg
module tcd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcd_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output tcd_pkg::cmd_t rd_cmd,
	output logic          empty
);

	tcd_pkg::cmd_t                 mem [tcd_pkg::QDEPTH];
	logic [tcd_pkg::QIDX_W-1:0]    wr_ptr_q;
	logic [tcd_pkg::QIDX_W-1:0]    rd_ptr_q;
	logic [tcd_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (count_q == tcd_pkg::QCNT_W'(tcd_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== sv/tcd_back.sv =====
// back end: vertex store, plane registers, shared multiply-accumulate sequencer,
// bit-serial divider and result register; depends on tcd_pkg
module tcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tcd_pkg::cmd_t       q_cmd,
	input  logic                q_empty,
	output logic                q_pop,
	output tcd_pkg::out_item_t  result,
	output logic                empty,
	input  logic                pop
);

	localparam int CW = tcd_pkg::COORD_W;
	localparam int OW = tcd_pkg::OPND_W;
	localparam int AW = tcd_pkg::ACC_W;
	localparam int PW = tcd_pkg::PLANE_W;
	localparam int HW = tcd_pkg::HALF_W;
	localparam int RW = tcd_pkg::REM_W;
	localparam logic [CW-1:0] POS_LIM = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] NEG_LIM = {1'b1, {(CW-1){1'b0}}};

	tcd_pkg::bk_state_t state_q, state_d;

	logic signed [CW-1:0]            vert_q [9];
	logic signed [PW-1:0]            plane_a_q, plane_b_q, plane_c_q;
	logic signed [tcd_pkg::DET_W-1:0] plane_det_q;
	tcd_pkg::cmd_t                   cur_q;
	logic [tcd_pkg::STEP_W-1:0]      step_q;
	logic [tcd_pkg::STEP_W-1:0]      last_step;
	logic                            is_test;

	// multiply-accumulate pipe
	logic signed [OW-1:0]            mul_a, mul_b;
	tcd_pkg::mac_tag_t               tag_d;
	logic signed [tcd_pkg::PROD_W-1:0] p_s1;
	tcd_pkg::mac_tag_t               tag_s1;
	logic signed [AW-1:0]            acc_q, acc_next, addend, base;
	logic                            acc_pos, acc_neg;
	logic [2:0]                      epos_q, eneg_q;
	logic signed [AW-1:0]            num_q;

	// divider
	logic [AW-1:0]                   dvd_q, quo_q;
	logic [RW-1:0]                   rem_q, trial;
	logic [PW-1:0]                   dsr_q;
	logic                            qneg_q;
	logic [tcd_pkg::DIVCNT_W-1:0]    cnt_q;
	logic                            take;

	tcd_pkg::out_item_t              res_q;
	logic                            res_valid_q;
	logic                            issue;
	logic                            start;
	logic [CW-1:0]                   sat;
	logic                            over;

	// plane halves for the split wide products
	logic signed [OW-1:0] a_hi, a_lo, b_hi, b_lo, c_hi, c_lo;
	logic signed [OW-1:0] px, py;

	assign is_test   = (cur_q.op == tcd_pkg::OP_TEST);
	assign last_step = is_test ? tcd_pkg::TEST_LAST : tcd_pkg::BUILD_LAST;
	assign a_hi = OW'($signed(plane_a_q[PW-1:HW]));
	assign b_hi = OW'($signed(plane_b_q[PW-1:HW]));
	assign c_hi = OW'($signed(plane_c_q[PW-1:HW]));
	assign a_lo = OW'({1'b0, plane_a_q[HW-1:0]});
	assign b_lo = OW'({1'b0, plane_b_q[HW-1:0]});
	assign c_lo = OW'({1'b0, plane_c_q[HW-1:0]});
	assign px   = OW'(cur_q.x);
	assign py   = OW'(cur_q.y);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcd_pkg::BK_IDLE: begin
				if (start && q_cmd.op != tcd_pkg::OP_LOAD) state_d = tcd_pkg::BK_MAC;
			end
			tcd_pkg::BK_MAC: begin
				if (step_q == last_step) state_d = tcd_pkg::BK_DRAIN;
			end
			tcd_pkg::BK_DRAIN: begin
				state_d = is_test ? tcd_pkg::BK_SETUP : tcd_pkg::BK_IDLE;
			end
			tcd_pkg::BK_SETUP: state_d = tcd_pkg::BK_DIV;
			tcd_pkg::BK_DIV: begin
				if (cnt_q == tcd_pkg::DIV_LAST) state_d = tcd_pkg::BK_DONE;
			end
			tcd_pkg::BK_DONE: state_d = tcd_pkg::BK_IDLE;
			default: state_d = tcd_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		start = (state_q == tcd_pkg::BK_IDLE) && !q_empty &&
			(q_cmd.op != tcd_pkg::OP_TEST || !res_valid_q);
		q_pop = start;
		issue = (state_q == tcd_pkg::BK_MAC);
	end

	// step table: one product per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		tag_d = '0;
		tag_d.dst = tcd_pkg::DST_A;
		if (is_test) begin
			case (step_q)
				4'd0: begin
					mul_a = tcd_pkg::diff(vert_q[3], vert_q[0]);
					mul_b = tcd_pkg::diff(cur_q.y, vert_q[1]);
					tag_d.first = 1'b1;
				end
				4'd1: begin
					mul_a = tcd_pkg::diff(vert_q[4], vert_q[1]);
					mul_b = tcd_pkg::diff(cur_q.x, vert_q[0]);
					tag_d.neg = 1'b1; tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_E0;
				end
				4'd2: begin
					mul_a = tcd_pkg::diff(vert_q[6], vert_q[3]);
					mul_b = tcd_pkg::diff(cur_q.y, vert_q[4]);
					tag_d.first = 1'b1;
				end
				4'd3: begin
					mul_a = tcd_pkg::diff(vert_q[7], vert_q[4]);
					mul_b = tcd_pkg::diff(cur_q.x, vert_q[3]);
					tag_d.neg = 1'b1; tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_E1;
				end
				4'd4: begin
					mul_a = tcd_pkg::diff(vert_q[0], vert_q[6]);
					mul_b = tcd_pkg::diff(cur_q.y, vert_q[7]);
					tag_d.first = 1'b1;
				end
				4'd5: begin
					mul_a = tcd_pkg::diff(vert_q[1], vert_q[7]);
					mul_b = tcd_pkg::diff(cur_q.x, vert_q[6]);
					tag_d.neg = 1'b1; tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_E2;
				end
				4'd6: begin
					mul_a = a_hi; mul_b = px;
					tag_d.neg = 1'b1; tag_d.shift = 1'b1;
					tag_d.first = 1'b1; tag_d.init_det = 1'b1;
				end
				4'd7: begin
					mul_a = a_lo; mul_b = px; tag_d.neg = 1'b1;
				end
				4'd8: begin
					mul_a = b_hi; mul_b = py; tag_d.neg = 1'b1; tag_d.shift = 1'b1;
				end
				4'd9: begin
					mul_a = b_lo; mul_b = py;
					tag_d.neg = 1'b1; tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_NUM;
				end
				default: ;
			endcase
		end else begin
			case (step_q)
				4'd0: begin
					mul_a = tcd_pkg::diff(vert_q[4], vert_q[1]);
					mul_b = tcd_pkg::diff(vert_q[8], vert_q[2]);
					tag_d.first = 1'b1;
				end
				4'd1: begin
					mul_a = tcd_pkg::diff(vert_q[7], vert_q[1]);
					mul_b = tcd_pkg::diff(vert_q[5], vert_q[2]);
					tag_d.neg = 1'b1; tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_A;
				end
				4'd2: begin
					mul_a = tcd_pkg::diff(vert_q[6], vert_q[0]);
					mul_b = tcd_pkg::diff(vert_q[5], vert_q[2]);
					tag_d.first = 1'b1;
				end
				4'd3: begin
					mul_a = tcd_pkg::diff(vert_q[3], vert_q[0]);
					mul_b = tcd_pkg::diff(vert_q[8], vert_q[2]);
					tag_d.neg = 1'b1; tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_B;
				end
				4'd4: begin
					mul_a = tcd_pkg::diff(vert_q[3], vert_q[0]);
					mul_b = tcd_pkg::diff(vert_q[7], vert_q[1]);
					tag_d.first = 1'b1;
				end
				4'd5: begin
					mul_a = tcd_pkg::diff(vert_q[6], vert_q[0]);
					mul_b = tcd_pkg::diff(vert_q[4], vert_q[1]);
					tag_d.neg = 1'b1; tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_C;
				end
				// determinant as the first vertex dotted with the plane normal
				4'd6: begin
					mul_a = OW'(vert_q[0]); mul_b = a_hi;
					tag_d.shift = 1'b1; tag_d.first = 1'b1;
				end
				4'd7: begin
					mul_a = OW'(vert_q[0]); mul_b = a_lo;
				end
				4'd8: begin
					mul_a = OW'(vert_q[1]); mul_b = b_hi; tag_d.shift = 1'b1;
				end
				4'd9: begin
					mul_a = OW'(vert_q[1]); mul_b = b_lo;
				end
				4'd10: begin
					mul_a = OW'(vert_q[2]); mul_b = c_hi; tag_d.shift = 1'b1;
				end
				4'd11: begin
					mul_a = OW'(vert_q[2]); mul_b = c_lo;
					tag_d.last = 1'b1; tag_d.dst = tcd_pkg::DST_D;
				end
				default: ;
			endcase
		end
		tag_d.valid = issue;
	end

	// accumulate stage
	always_comb begin
		addend = tag_s1.shift ? (AW'(p_s1) <<< HW) : AW'(p_s1);
		if (tag_s1.first) begin
			base = tag_s1.init_det ? AW'(plane_det_q) : '0;
		end else begin
			base = acc_q;
		end
		acc_next = tag_s1.neg ? (base - addend) : (base + addend);
		acc_neg  = acc_next[AW-1];
		acc_pos  = !acc_next[AW-1] && (acc_next != '0);
	end

	// one quotient bit per cycle
	always_comb begin
		trial = {rem_q[RW-2:0], dvd_q[AW-1]};
		take  = (trial >= RW'(dsr_q));
	end

	// saturate the quotient magnitude to the depth range
	always_comb begin
		if (qneg_q) begin
			over = (|quo_q[AW-1:CW]) || (quo_q[CW-1] && (|quo_q[CW-2:0]));
			sat  = over ? NEG_LIM : (CW'(0) - quo_q[CW-1:0]);
		end else begin
			over = |quo_q[AW-1:CW-1];
			sat  = over ? POS_LIM : quo_q[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcd_pkg::BK_IDLE;
			tag_s1      <= '0;
			res_valid_q <= 1'b0;
			plane_a_q   <= '0;
			plane_b_q   <= '0;
			plane_c_q   <= '0;
			plane_det_q <= '0;
			for (int i = 0; i < 9; i++) vert_q[i] <= '0;
		end else begin
			state_q <= state_d;
			tag_s1  <= tag_d;
			if (start && q_cmd.op == tcd_pkg::OP_LOAD) begin
				for (int i = 0; i < 3; i++) begin
					if (q_cmd.sel == 2'(i)) begin
						vert_q[3*i]   <= q_cmd.x;
						vert_q[3*i+1] <= q_cmd.y;
						vert_q[3*i+2] <= q_cmd.z;
					end
				end
			end
			if (tag_s1.valid && tag_s1.last) begin
				case (tag_s1.dst)
					tcd_pkg::DST_A: plane_a_q <= acc_next[PW-1:0];
					tcd_pkg::DST_B: plane_b_q <= acc_next[PW-1:0];
					tcd_pkg::DST_C: plane_c_q <= acc_next[PW-1:0];
					tcd_pkg::DST_D: plane_det_q <= acc_next[tcd_pkg::DET_W-1:0];
					default: ;
				endcase
			end
			if (state_q == tcd_pkg::BK_DONE) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q  <= q_cmd;
			step_q <= '0;
		end else if (issue) begin
			step_q <= step_q + 1'b1;
		end
		p_s1 <= mul_a * mul_b;
		if (tag_s1.valid) begin
			acc_q <= acc_next;
			if (tag_s1.last) begin
				case (tag_s1.dst)
					tcd_pkg::DST_E0: begin epos_q[0] <= acc_pos; eneg_q[0] <= acc_neg; end
					tcd_pkg::DST_E1: begin epos_q[1] <= acc_pos; eneg_q[1] <= acc_neg; end
					tcd_pkg::DST_E2: begin epos_q[2] <= acc_pos; eneg_q[2] <= acc_neg; end
					tcd_pkg::DST_NUM: num_q <= acc_next;
					default: ;
				endcase
			end
		end
		if (state_q == tcd_pkg::BK_SETUP) begin
			dvd_q  <= num_q[AW-1] ? (AW'(0) - num_q) : num_q;
			dsr_q  <= plane_c_q[PW-1] ? (PW'(0) - plane_c_q) : plane_c_q;
			qneg_q <= num_q[AW-1] ^ plane_c_q[PW-1];
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else if (state_q == tcd_pkg::BK_DIV) begin
			rem_q <= take ? (trial - RW'(dsr_q)) : trial;
			quo_q <= {quo_q[AW-2:0], take};
			dvd_q <= {dvd_q[AW-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == tcd_pkg::BK_DONE) begin
			res_q.inside_res  <= !((|epos_q) && (|eneg_q));
			res_q.depth_valid <= (plane_c_q != '0);
			res_q.depth       <= (plane_c_q != '0) ? sat : '0;
		end
	end

	assign result = res_q;
	assign empty  = !res_valid_q;

endmodule
